/* rtl/dscw_pkg.sv */
package dscw_pkg;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [APB_AW-1:0] ADDR_OPERATIONAL = 3'd0;
  localparam logic [APB_AW-1:0] ADDR_CLOCK_LOSS_LIMIT = 3'd4;

  localparam logic [7:0] CLOCK_LOSS_LIMIT_RESET = 8'd20;
  localparam logic [7:0] LOST_COUNT_MAX = 8'hFF;

  typedef enum logic [1:0] {
    TGT_STOP    = 2'd0,
    TGT_DISABLE = 2'd1,
    TGT_ENABLE  = 2'd2
  } target_t;

  typedef enum logic [3:0] {
    DS_NOT_READY      = 4'd0,
    DS_DISABLED       = 4'd1,
    DS_READY          = 4'd2,
    DS_SWITCHED_ON    = 4'd3,
    DS_ENABLED        = 4'd4,
    DS_FAULT          = 4'd5,
    DS_FAULT_REACTION = 4'd6,
    DS_QUICK_STOP     = 4'd7,
    DS_UNKNOWN        = 4'd8
  } drive_state_t;

  typedef enum logic [2:0] {
    TR_SHUTDOWN        = 3'd0,
    TR_SWITCH_ON       = 3'd1,
    TR_DISABLE_VOLTAGE = 3'd2,
    TR_QUICK_STOP      = 3'd3,
    TR_DISABLE_OP      = 3'd4,
    TR_ENABLE_OP       = 3'd5,
    TR_FAULT_RESET     = 3'd6
  } transition_t;

  localparam logic [15:0] QS_MASK  = 16'h006F;
  localparam logic [15:0] QS_VALUE = 16'h0007;
  localparam logic [15:0] ST_MASK  = 16'h004F;

  localparam logic [15:0] SW_NOT_READY      = 16'h0000;
  localparam logic [15:0] SW_DISABLED       = 16'h0040;
  localparam logic [15:0] SW_READY          = 16'h0001;
  localparam logic [15:0] SW_SWITCHED_ON    = 16'h0003;
  localparam logic [15:0] SW_ENABLED        = 16'h0007;
  localparam logic [15:0] SW_FAULT          = 16'h0008;
  localparam logic [15:0] SW_FAULT_REACTION = 16'h000F;

  localparam logic [15:0] CMD_LOW3       = 16'h0087;
  localparam logic [15:0] CMD_LOW4       = 16'h008F;
  localparam logic [15:0] CW_QS_KEEP     = 16'h0004;
  localparam logic [15:0] CW_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CW_SWITCH_ON   = 16'h0007;
  localparam logic [15:0] CW_ENABLE_OP   = 16'h000F;
  localparam logic [15:0] CW_DISABLE_OP  = 16'h0007;
  localparam logic [15:0] CW_FAULT_RESET = 16'h0080;
  localparam int unsigned MOVE_BIT       = 4;

  function automatic logic [15:0] set_bits(input logic [15:0] cw, input logic [15:0] clr,
                                           input logic [15:0] set);
    return (cw & ~clr) | set;
  endfunction

endpackage

/* rtl/drive_state_control_word.sv */
// Drive state and control word generator. One item is taken per controller cycle: the
// status word is registered on input, decoded into a drive state and a new control word
// in one combinational pass, and the result is held in an output register until it is
// transferred. An item can be transferred in on every clock while the output side does
// not stall, and the rate is then one item per cycle, set by the single update of the
// control, target and clock-loss registers per item. The operational flag and the
// clock-loss limit must be written through the APB port while no item is in flight;
// the block itself does not enforce it.
module drive_state_control_word (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dscw_pkg::APB_AW-1:0]  paddr,
  input  logic [dscw_pkg::APB_DW-1:0]  pwdata,
  output logic [dscw_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  in_status_word,
  input  logic                         in_clock_advanced,
  input  logic                         in_target_valid,
  input  logic [1:0]                   in_target_request,
  input  logic                         in_move_request,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [15:0]                  out_control_word,
  output logic [3:0]                   out_drive_state,
  output logic [2:0]                   out_transition_code,
  output logic [1:0]                   out_current_target
);
  import dscw_pkg::*;

  logic        oper_r;
  logic [7:0]  limit_r;
  logic        cfg_wr;

  logic        s1_valid_r;
  logic [15:0] s1_status_r;
  logic        s1_adv_r;
  logic        s1_tv_r;
  logic [1:0]  s1_treq_r;
  logic        s1_move_r;

  logic        out_valid_r;
  logic [15:0] out_cw_r;
  logic [3:0]  out_ds_r;
  logic [2:0]  out_tr_r;
  logic [1:0]  out_tgt_r;

  logic [15:0] control_r, control_nxt;
  logic [1:0]  target_r, target_nxt;
  logic [7:0]  lost_cnt_r, lost_cnt_nxt;
  logic [2:0]  last_tr_r, last_tr_nxt;
  drive_state_t ds_nxt;

  logic s2_free;
  logic s_adv;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      ADDR_OPERATIONAL[2]: prdata = {{(APB_DW-1){1'b0}}, oper_r};
      default: prdata = {{(APB_DW-8){1'b0}}, limit_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oper_r  <= 1'b0;
      limit_r <= CLOCK_LOSS_LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ADDR_OPERATIONAL[2]) begin
        oper_r <= pwdata[0];
      end else begin
        limit_r <= pwdata[7:0];
      end
    end
  end

  assign s2_free  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_free;
  assign s_adv    = s1_valid_r && s2_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_status_r <= in_status_word;
      s1_adv_r    <= in_clock_advanced;
      s1_tv_r     <= in_target_valid;
      s1_treq_r   <= in_target_request;
      s1_move_r   <= in_move_request;
    end
  end

  always_comb begin
    logic [15:0] cw;
    logic [1:0]  tgt;
    cw  = control_r;
    tgt = target_r;
    last_tr_nxt = last_tr_r;
    ds_nxt = DS_UNKNOWN;

    if (s1_tv_r && (s1_treq_r == TGT_STOP || s1_treq_r == TGT_DISABLE ||
                    s1_treq_r == TGT_ENABLE)) begin
      tgt = s1_treq_r;
    end

    if (s1_adv_r) begin
      lost_cnt_nxt = '0;
    end else if (lost_cnt_r != LOST_COUNT_MAX) begin
      lost_cnt_nxt = lost_cnt_r + 8'd1;
    end else begin
      lost_cnt_nxt = lost_cnt_r;
    end
    if (lost_cnt_nxt > limit_r) begin
      tgt = TGT_STOP;
    end

    if (oper_r) begin
      if ((s1_status_r & QS_MASK) == QS_VALUE) begin
        ds_nxt = DS_QUICK_STOP;
        last_tr_nxt = TR_DISABLE_OP;
        cw = cw & CW_QS_KEEP;
      end else begin
        case (s1_status_r & ST_MASK)
          SW_NOT_READY: begin
            ds_nxt = DS_NOT_READY;
            last_tr_nxt = TR_SHUTDOWN;
          end
          SW_DISABLED: begin
            ds_nxt = DS_DISABLED;
            last_tr_nxt = TR_SHUTDOWN;
            cw = set_bits(cw, CMD_LOW3, CW_SHUTDOWN);
          end
          SW_READY: begin
            ds_nxt = DS_READY;
            last_tr_nxt = TR_SWITCH_ON;
            if (tgt == TGT_ENABLE || tgt == TGT_DISABLE) begin
              cw = set_bits(cw, CMD_LOW3, CW_SWITCH_ON);
            end
          end
          SW_SWITCHED_ON: begin
            ds_nxt = DS_SWITCHED_ON;
            if (tgt == TGT_STOP) begin
              last_tr_nxt = TR_SHUTDOWN;
              cw = set_bits(cw, CMD_LOW4, CW_SHUTDOWN);
            end else if (tgt == TGT_ENABLE) begin
              last_tr_nxt = TR_ENABLE_OP;
              cw = set_bits(cw, CMD_LOW4, CW_ENABLE_OP);
            end
          end
          SW_ENABLED: begin
            ds_nxt = DS_ENABLED;
            if (tgt != TGT_ENABLE) begin
              last_tr_nxt = TR_DISABLE_OP;
              cw = set_bits(cw, CMD_LOW4, CW_DISABLE_OP);
            end
          end
          SW_FAULT: begin
            ds_nxt = DS_FAULT;
            last_tr_nxt = TR_FAULT_RESET;
            cw = cw | CW_FAULT_RESET;
          end
          SW_FAULT_REACTION: begin
            ds_nxt = DS_FAULT_REACTION;
            last_tr_nxt = TR_SHUTDOWN;
            cw = set_bits(cw, CMD_LOW3, CW_SHUTDOWN);
          end
          default: begin
            ds_nxt = DS_UNKNOWN;
            last_tr_nxt = TR_SHUTDOWN;
            cw = set_bits(cw, CMD_LOW3, CW_SHUTDOWN);
          end
        endcase
      end
    end

    cw[MOVE_BIT] = s1_move_r;
    control_nxt  = cw;
    target_nxt   = tgt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= '0;
      target_r    <= TGT_STOP;
      lost_cnt_r  <= '0;
      last_tr_r   <= TR_SHUTDOWN;
      out_valid_r <= 1'b0;
    end else begin
      if (s_adv) begin
        control_r  <= control_nxt;
        target_r   <= target_nxt;
        lost_cnt_r <= lost_cnt_nxt;
        last_tr_r  <= last_tr_nxt;
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv) begin
      out_cw_r  <= control_nxt;
      out_ds_r  <= ds_nxt;
      out_tr_r  <= last_tr_nxt;
      out_tgt_r <= target_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_control_word    = out_cw_r;
  assign out_drive_state     = out_ds_r;
  assign out_transition_code = out_tr_r;
  assign out_current_target  = out_tgt_r;

  // A stale clock must leave the target at stop after the update.
  a_clock_loss_stop: assert property (@(posedge clk) disable iff (!rst_n)
    s_adv |=> (lost_cnt_r <= $past(limit_r) || target_r == TGT_STOP))
    else $error("target not forced to stop after clock loss");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s_adv |=> (out_valid_r && out_control_word == control_r &&
               out_current_target == target_r))
    else $error("result register does not match the updated state");

  a_move_bit: assert property (@(posedge clk) disable iff (!rst_n)
    s_adv |=> (out_control_word[MOVE_BIT] == $past(s1_move_r)))
    else $error("move bit does not follow the request");

  a_not_operational: assert property (@(posedge clk) disable iff (!rst_n)
    s_adv |=> ($past(oper_r) || (out_drive_state == DS_UNKNOWN &&
               out_transition_code == $past(last_tr_r))))
    else $error("status decoded while not operational");

endmodule

/* tb/drive_state_control_word_checker.sv */
`timescale 1ns / 1ps

module drive_state_control_word_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dscw_pkg::APB_AW-1:0] paddr,
  input  logic [dscw_pkg::APB_DW-1:0] pwdata,
  input  logic                        pready,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [15:0]                 in_status_word,
  input  logic                        in_clock_advanced,
  input  logic                        in_target_valid,
  input  logic [1:0]                  in_target_request,
  input  logic                        in_move_request,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [15:0]                 out_control_word,
  input  logic [3:0]                  out_drive_state,
  input  logic [2:0]                  out_transition_code,
  input  logic [1:0]                  out_current_target,
  output int                          errors,
  output int                          results_checked,
  output int                          outstanding,
  output logic [8:0]                  states_seen
);
  import dscw_pkg::*;

  typedef struct {
    logic [15:0]  control_word;
    drive_state_t drive_state;
    transition_t  transition_code;
    target_t      current_target;
  } drive_result_t;

  drive_result_t expected_results[$];

  logic        operational;
  logic [7:0]  loss_limit;
  logic [15:0] control_now;
  target_t     target_now;
  logic [7:0]  lost_clocks;
  transition_t transition_now;

  function drive_result_t next_control_word(input logic [15:0] status, input logic advanced,
                                            input logic tgt_valid, input logic [1:0] tgt_req,
                                            input logic move);
    drive_result_t r;
    logic [15:0]   cw;
    cw = control_now;
    r.drive_state = DS_UNKNOWN;
    if (tgt_valid && tgt_req <= TGT_ENABLE) target_now = target_t'(tgt_req);
    if (advanced) lost_clocks = '0;
    else if (lost_clocks != LOST_COUNT_MAX) lost_clocks = lost_clocks + 8'd1;
    if (lost_clocks > loss_limit) target_now = TGT_STOP;
    if (operational) begin
      if ((status & QS_MASK) == QS_VALUE) begin
        r.drive_state = DS_QUICK_STOP;
        transition_now = TR_DISABLE_OP;
        cw = cw & CW_QS_KEEP;
      end else begin
        case (status & ST_MASK)
          SW_NOT_READY: begin
            r.drive_state = DS_NOT_READY;
            transition_now = TR_SHUTDOWN;
          end
          SW_DISABLED: begin
            r.drive_state = DS_DISABLED;
            transition_now = TR_SHUTDOWN;
            cw = (cw & ~CMD_LOW3) | CW_SHUTDOWN;
          end
          SW_READY: begin
            r.drive_state = DS_READY;
            transition_now = TR_SWITCH_ON;
            if (target_now != TGT_STOP) cw = (cw & ~CMD_LOW3) | CW_SWITCH_ON;
          end
          SW_SWITCHED_ON: begin
            r.drive_state = DS_SWITCHED_ON;
            if (target_now == TGT_STOP) begin
              transition_now = TR_SHUTDOWN;
              cw = (cw & ~CMD_LOW4) | CW_SHUTDOWN;
            end else if (target_now == TGT_ENABLE) begin
              transition_now = TR_ENABLE_OP;
              cw = (cw & ~CMD_LOW4) | CW_ENABLE_OP;
            end
          end
          SW_ENABLED: begin
            r.drive_state = DS_ENABLED;
            if (target_now != TGT_ENABLE) begin
              transition_now = TR_DISABLE_OP;
              cw = (cw & ~CMD_LOW4) | CW_DISABLE_OP;
            end
          end
          SW_FAULT: begin
            r.drive_state = DS_FAULT;
            transition_now = TR_FAULT_RESET;
            cw = cw | CW_FAULT_RESET;
          end
          SW_FAULT_REACTION: begin
            r.drive_state = DS_FAULT_REACTION;
            transition_now = TR_SHUTDOWN;
            cw = (cw & ~CMD_LOW3) | CW_SHUTDOWN;
          end
          default: begin
            r.drive_state = DS_UNKNOWN;
            transition_now = TR_SHUTDOWN;
            cw = (cw & ~CMD_LOW3) | CW_SHUTDOWN;
          end
        endcase
      end
    end
    cw[MOVE_BIT] = move;
    control_now = cw;
    r.control_word = cw;
    r.transition_code = transition_now;
    r.current_target = target_now;
    return r;
  endfunction

  function void check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    drive_result_t r;
    if (!rst_n) begin
      operational = 1'b0;
      loss_limit = CLOCK_LOSS_LIMIT_RESET;
      control_now = '0;
      target_now = TGT_STOP;
      lost_clocks = '0;
      transition_now = TR_SHUTDOWN;
      expected_results.delete();
      errors = 0;
      results_checked = 0;
      states_seen = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_OPERATIONAL:      operational = pwdata[0];
          ADDR_CLOCK_LOSS_LIMIT: loss_limit = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        r = next_control_word(in_status_word, in_clock_advanced, in_target_valid,
                              in_target_request, in_move_request);
        expected_results.push_back(r);
        states_seen[r.drive_state] = 1'b1;
      end
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected, control_word %0h",
                   $time, out_control_word);
        end else begin
          r = expected_results.pop_front();
          check_field("control_word", r.control_word, out_control_word);
          check_field("drive_state", 16'(r.drive_state), 16'(out_drive_state));
          check_field("transition_code", 16'(r.transition_code), 16'(out_transition_code));
          check_field("current_target", 16'(r.current_target), 16'(out_current_target));
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

/* tb/drive_state_control_word_test.sv */
`timescale 1ns / 1ps

module drive_state_control_word_test;
  import dscw_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 10;
  localparam int LONG_LOSS_RUN = 280;
  localparam int NUM_PHASES = 7;
  localparam logic [1:0] TGT_UNUSED = 2'd3;
  // Bit 5 is what separates operation enabled from quick stop.
  localparam logic [15:0] QS_CLEAR = QS_MASK & ~ST_MASK;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [15:0]       in_status_word = '0;
  logic              in_clock_advanced = 1'b0;
  logic              in_target_valid = 1'b0;
  logic [1:0]        in_target_request = '0;
  logic              in_move_request = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [15:0]       out_control_word;
  logic [3:0]        out_drive_state;
  logic [2:0]        out_transition_code;
  logic [1:0]        out_current_target;

  int          errors;
  int          results_checked;
  int          outstanding;
  logic [8:0]  states_seen;
  int          items_sent = 0;
  int          settings_applied = 0;
  int          idle_cycles = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned loss_left = 0;

  bit         phase_oper  [NUM_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
  logic [7:0] phase_limit [NUM_PHASES] = '{8'd20, 8'd0, 8'd7, 8'd254, 8'd255, 8'd3, 8'd1};
  int         phase_items [NUM_PHASES] = '{330, 150, 100, 450, 150, 200, 150};

  always #1 clk = ~clk;

  drive_state_control_word dut (.*);

  drive_state_control_word_checker cw_check (.*);

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_settings(input bit oper, input logic [7:0] limit);
    write_reg(ADDR_OPERATIONAL, APB_DW'(oper));
    write_reg(ADDR_CLOCK_LOSS_LIMIT, APB_DW'(limit));
    settings_applied++;
  endtask

  task automatic send_item(input logic [15:0] sw, input logic adv, input logic tv,
                           input logic [1:0] req, input logic mv);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_status_word <= sw;
    in_clock_advanced <= adv;
    in_target_valid <= tv;
    in_target_request <= req;
    in_move_request <= mv;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_random_item();
    logic [15:0] noise;
    logic [15:0] sw;
    logic        adv;
    noise = 16'($urandom);
    case ($urandom_range(0, 19))
      0, 1:      sw = (noise & ~ST_MASK) | SW_NOT_READY;
      2, 3:      sw = (noise & ~ST_MASK) | SW_DISABLED;
      4, 5, 6:   sw = (noise & ~ST_MASK) | SW_READY;
      7, 8, 9:   sw = (noise & ~ST_MASK) | SW_SWITCHED_ON;
      10, 11, 12: sw = (noise & ~QS_MASK) | SW_ENABLED | QS_CLEAR;
      13:        sw = (noise & ~ST_MASK) | SW_FAULT;
      14:        sw = (noise & ~ST_MASK) | SW_FAULT_REACTION;
      15, 16:    sw = (noise & ~QS_MASK) | QS_VALUE;
      default:   sw = noise;
    endcase
    if (loss_left != 0) begin
      adv = 1'b0;
      loss_left--;
    end else if ($urandom_range(0, 39) == 0) begin
      adv = 1'b0;
      loss_left = $urandom_range(0, 40);
    end else begin
      adv = 1'b1;
    end
    send_item(sw, adv, $urandom_range(0, 3) == 0, 2'($urandom_range(0, 3)), 1'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_checked != items_sent) @(posedge clk);
  endtask

  initial begin
    int p;
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Link not yet operational: only the move bit and the target may change.
    send_item(16'hFFFF, 1'b1, 1'b1, TGT_ENABLE, 1'b1);
    send_item(SW_NOT_READY, 1'b0, 1'b1, TGT_UNUSED, 1'b0);
    drain();

    write_settings(1'b1, CLOCK_LOSS_LIMIT_RESET);
    send_item(SW_DISABLED, 1'b1, 1'b1, TGT_DISABLE, 1'b0);
    send_item(SW_READY, 1'b1, 1'b0, TGT_UNUSED, 1'b1);
    send_item(SW_SWITCHED_ON, 1'b1, 1'b0, TGT_STOP, 1'b0);
    send_item(SW_SWITCHED_ON, 1'b1, 1'b1, TGT_ENABLE, 1'b1);
    send_item(SW_ENABLED | QS_CLEAR, 1'b1, 1'b0, TGT_UNUSED, 1'b1);
    send_item(16'hFF90 | SW_ENABLED | QS_CLEAR, 1'b1, 1'b1, TGT_STOP, 1'b0);
    send_item(SW_READY, 1'b1, 1'b0, TGT_ENABLE, 1'b1);
    send_item(SW_SWITCHED_ON, 1'b1, 1'b0, TGT_DISABLE, 1'b0);
    send_item(QS_VALUE, 1'b1, 1'b0, TGT_STOP, 1'b1);
    send_item(SW_FAULT, 1'b1, 1'b0, TGT_STOP, 1'b0);
    send_item(SW_FAULT_REACTION, 1'b1, 1'b0, TGT_STOP, 1'b1);
    send_item(SW_NOT_READY, 1'b1, 1'b0, TGT_STOP, 1'b0);
    send_item(16'h0002, 1'b1, 1'b0, TGT_STOP, 1'b1);
    send_item(16'hFFFF, 1'b1, 1'b0, TGT_STOP, 1'b0);
    send_item(SW_READY, 1'b1, 1'b1, TGT_ENABLE, 1'b1);
    send_item(SW_SWITCHED_ON, 1'b1, 1'b1, TGT_UNUSED, 1'b0);
    drain();

    // With a small limit the third item without clock advance forces a stop.
    write_settings(1'b1, 8'd2);
    send_item(SW_ENABLED | QS_CLEAR, 1'b0, 1'b0, TGT_STOP, 1'b0);
    send_item(SW_ENABLED | QS_CLEAR, 1'b0, 1'b0, TGT_STOP, 1'b1);
    send_item(SW_ENABLED | QS_CLEAR, 1'b0, 1'b1, TGT_ENABLE, 1'b0);
    send_item(SW_SWITCHED_ON, 1'b1, 1'b1, TGT_ENABLE, 1'b1);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_settings(phase_oper[p], phase_limit[p]);
      if (phase_limit[p] >= 8'd254) loss_left = LONG_LOSS_RUN;
      for (n = 0; n < phase_items[p]; n++) send_random_item();
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Run covered %0d item transfers under %0d register settings, including a",
             items_sent, settings_applied);
    $display("long output stall and saturating clock loss; drive states predicted: %b",
             states_seen);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    int          taken;
    taken = 0;
    forever begin
      if (taken == 150 || taken == 800) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) rx_burst = !rx_burst;
      gap = rx_burst ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready && rst_n));
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired after %0d cycles without a transfer", $time, idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
